/* hw/rtl/llc_pkg.sv */
// Shared constants for the linked-list cursor engine: field widths, command and status codes.
`default_nettype none
package llc_pkg;

    localparam int NODE_COUNT_DEF = 256;

    localparam int OP_W  = 4;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;

    typedef logic [OP_W-1:0] t_op;
    typedef logic [ST_W-1:0] t_status;

    localparam t_op OP_CLEAR      = 4'd0;
    localparam t_op OP_INS_HEAD   = 4'd1;
    localparam t_op OP_CUR_TO_HEAD = 4'd2;
    localparam t_op OP_READ_HEAD  = 4'd3;
    localparam t_op OP_DEL_HEAD   = 4'd4;
    localparam t_op OP_DEL_AFTER  = 4'd5;
    localparam t_op OP_INS_AFTER  = 4'd6;
    localparam t_op OP_READ_CUR   = 4'd7;
    localparam t_op OP_WRITE_CUR  = 4'd8;
    localparam t_op OP_ADVANCE    = 4'd9;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_NO_NODE = 2'd1;
    localparam t_status ST_FULL    = 2'd2;

endpackage
`default_nettype wire

/* hw/rtl/llc_cmd_if.sv */
// Command channel interface: valid/ready handshake carrying op and value.
`default_nettype none
interface llc_cmd_if;
    logic                               valid;
    logic                               ready;
    llc_pkg::t_op                       op;
    logic signed [llc_pkg::VAL_W-1:0]   value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface
`default_nettype wire

/* hw/rtl/llc_rsp_if.sv */
// Response channel interface: valid/ready handshake carrying one result per command.
`default_nettype none
interface llc_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [llc_pkg::VAL_W-1:0]   read_value;
    llc_pkg::t_status                   status;
    logic                               is_active;
    logic                               is_empty;

    modport source (output valid, output read_value, output status,
                    output is_active, output is_empty, input ready);
    modport sink   (input valid, input read_value, input status,
                    input is_active, input is_empty, output ready);
endinterface
`default_nettype wire

/* hw/rtl/linked_list_cursor_engine.sv */
// Top level: singly linked list with cursor, node pool in on-chip memories.
//
// Usage:
//   i_cmd carries one command transaction (op, value); o_rsp returns exactly
//   one response transaction per command (read_value, status, is_active,
//   is_empty), in command order.
//   Node values and node links live in two synchronous memories of
//   NODE_COUNT entries; head, cursor, free chain head and the never-used
//   count sit in flip-flops. A command walks a fixed sequencer:
//   accept, read 1, read 2, write 1, optional write 2, result.
//   A delete-after that unlinks a node and a successful insert-after
//   take the optional write 2 step, as they write the link memory twice.
//   The response sits in an output register, so the next command is
//   accepted while it waits; a stalled receiver only holds the sequencer
//   in its result step once the next response is ready.
//   Reset (i_rst_n low, synchronous) and the clear command empty the list,
//   the free chain and the never-used count at once; the memories keep
//   stale contents, which are never read before a node is allocated and written.
`default_nettype none
module linked_list_cursor_engine #(
    parameter int NODE_COUNT = llc_pkg::NODE_COUNT_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    llc_cmd_if.sink    i_cmd,
    llc_rsp_if.source  o_rsp
);

    localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int IW = $clog2(NODE_COUNT + 1);
    localparam logic [IW-1:0] NIL = IW'(NODE_COUNT);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD_A = 6'b000010,
        S_RD_B = 6'b000100,
        S_WR_A = 6'b001000,
        S_WR_B = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    typedef logic [IW-1:0]                   t_idx;
    typedef logic signed [llc_pkg::VAL_W-1:0] t_val;

    // node pool memories
    t_val r_vmem [NODE_COUNT];
    t_idx r_lmem [NODE_COUNT];
    t_val r_vq;
    t_idx r_lq;

    logic          vmem_re, vmem_we, lmem_re, lmem_we;
    logic [AW-1:0] vmem_raddr, vmem_waddr, lmem_raddr, lmem_waddr;
    t_val          vmem_wdata;
    t_idx          lmem_wdata;

    // control and list registers
    t_state r_state, n_state;
    llc_pkg::t_op r_op, n_op;
    t_val   r_val, n_val;
    t_idx   r_head, n_head;
    t_idx   r_cur, n_cur;
    t_idx   r_free, n_free;
    t_idx   r_nu, n_nu;
    t_idx   r_t1, n_t1;
    t_idx   r_node, n_node;
    t_val   r_rd, n_rd;
    llc_pkg::t_status r_status, n_status;

    // output register
    logic   r_oval, n_oval;
    t_val   r_o_rd, n_o_rd;
    llc_pkg::t_status r_o_st, n_o_st;
    logic   r_o_act, n_o_act;
    logic   r_o_emp, n_o_emp;

    function automatic logic live(input t_idx x);
        return x != NIL;
    endfunction

    function automatic logic [AW-1:0] addr(input t_idx x);
        return x[AW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (vmem_we) begin
            r_vmem[vmem_waddr] <= vmem_wdata;
        end
        if (vmem_re) begin
            r_vq <= r_vmem[vmem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (lmem_we) begin
            r_lmem[lmem_waddr] <= lmem_wdata;
        end
        if (lmem_re) begin
            r_lq <= r_lmem[lmem_raddr];
        end
    end

    always_comb begin
        t_idx node;
        logic got;

        node       = NIL;
        got        = 1'b0;
        n_state    = r_state;
        n_op       = r_op;
        n_val      = r_val;
        n_head     = r_head;
        n_cur      = r_cur;
        n_free     = r_free;
        n_nu       = r_nu;
        n_t1       = r_t1;
        n_node     = r_node;
        n_rd       = r_rd;
        n_status   = r_status;
        n_oval     = r_oval;
        n_o_rd     = r_o_rd;
        n_o_st     = r_o_st;
        n_o_act    = r_o_act;
        n_o_emp    = r_o_emp;
        vmem_re    = 1'b0;
        vmem_we    = 1'b0;
        lmem_re    = 1'b0;
        lmem_we    = 1'b0;
        vmem_raddr = '0;
        vmem_waddr = '0;
        lmem_raddr = '0;
        lmem_waddr = '0;
        vmem_wdata = r_val;
        lmem_wdata = '0;

        // drop the response once the receiver takes it
        if (r_oval && o_rsp.ready) begin
            n_oval = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_op    = i_cmd.op;
                    n_val   = i_cmd.value;
                    n_state = S_RD_A;
                end
            end

            // first read: link or value at head, cursor or free chain head
            S_RD_A: begin
                case (r_op)
                    llc_pkg::OP_INS_HEAD: begin
                        lmem_re    = live(r_free);
                        lmem_raddr = addr(r_free);
                    end
                    llc_pkg::OP_READ_HEAD: begin
                        vmem_re    = live(r_head);
                        vmem_raddr = addr(r_head);
                    end
                    llc_pkg::OP_DEL_HEAD: begin
                        lmem_re    = live(r_head);
                        lmem_raddr = addr(r_head);
                    end
                    llc_pkg::OP_DEL_AFTER, llc_pkg::OP_INS_AFTER, llc_pkg::OP_ADVANCE: begin
                        lmem_re    = live(r_cur);
                        lmem_raddr = addr(r_cur);
                    end
                    llc_pkg::OP_READ_CUR: begin
                        vmem_re    = live(r_cur);
                        vmem_raddr = addr(r_cur);
                    end
                    default: begin
                    end
                endcase
                n_state = S_RD_B;
            end

            // second read: link of the victim, or of the free chain head
            S_RD_B: begin
                n_t1 = r_lq;
                case (r_op)
                    llc_pkg::OP_DEL_AFTER: begin
                        lmem_re    = live(r_cur) && live(r_lq);
                        lmem_raddr = addr(r_lq);
                    end
                    llc_pkg::OP_INS_AFTER: begin
                        lmem_re    = live(r_cur) && live(r_free);
                        lmem_raddr = addr(r_free);
                    end
                    default: begin
                    end
                endcase
                n_state = S_WR_A;
            end

            S_WR_A: begin
                n_rd     = '0;
                n_status = llc_pkg::ST_OK;
                n_state  = S_DONE;
                case (r_op)
                    llc_pkg::OP_CLEAR: begin
                        n_head = NIL;
                        n_cur  = NIL;
                        n_free = NIL;
                        n_nu   = '0;
                    end
                    llc_pkg::OP_INS_HEAD: begin
                        if (live(r_free)) begin
                            node   = r_free;
                            got    = 1'b1;
                            n_free = r_lq;
                        end else if (live(r_nu)) begin
                            node   = r_nu;
                            got    = 1'b1;
                            n_nu   = r_nu + IW'(1);
                        end else begin
                            n_status = llc_pkg::ST_FULL;
                        end
                        if (got) begin
                            vmem_we    = 1'b1;
                            vmem_waddr = addr(node);
                            lmem_we    = 1'b1;
                            lmem_waddr = addr(node);
                            lmem_wdata = r_head;
                            n_head     = node;
                        end
                    end
                    llc_pkg::OP_CUR_TO_HEAD: begin
                        n_cur = r_head;
                    end
                    llc_pkg::OP_READ_HEAD: begin
                        if (live(r_head)) begin
                            n_rd = r_vq;
                        end else begin
                            n_status = llc_pkg::ST_NO_NODE;
                        end
                    end
                    llc_pkg::OP_DEL_HEAD: begin
                        if (r_cur == r_head) begin
                            n_cur = NIL;
                        end
                        if (live(r_head)) begin
                            lmem_we    = 1'b1;
                            lmem_waddr = addr(r_head);
                            lmem_wdata = r_free;
                            n_free     = r_head;
                            n_head     = r_lq;
                        end
                    end
                    llc_pkg::OP_DEL_AFTER: begin
                        // unlink the victim now, push it on the free chain next
                        if (live(r_cur) && live(r_t1)) begin
                            lmem_we    = 1'b1;
                            lmem_waddr = addr(r_cur);
                            lmem_wdata = r_lq;
                            n_state    = S_WR_B;
                        end
                    end
                    llc_pkg::OP_INS_AFTER: begin
                        if (live(r_cur)) begin
                            if (live(r_free)) begin
                                node   = r_free;
                                got    = 1'b1;
                                n_free = r_lq;
                            end else if (live(r_nu)) begin
                                node   = r_nu;
                                got    = 1'b1;
                                n_nu   = r_nu + IW'(1);
                            end else begin
                                n_status = llc_pkg::ST_FULL;
                            end
                        end
                        if (got) begin
                            vmem_we    = 1'b1;
                            vmem_waddr = addr(node);
                            lmem_we    = 1'b1;
                            lmem_waddr = addr(node);
                            lmem_wdata = r_t1;
                            n_node     = node;
                            n_state    = S_WR_B;
                        end
                    end
                    llc_pkg::OP_READ_CUR: begin
                        if (live(r_cur)) begin
                            n_rd = r_vq;
                        end else begin
                            n_status = llc_pkg::ST_NO_NODE;
                        end
                    end
                    llc_pkg::OP_WRITE_CUR: begin
                        if (live(r_cur)) begin
                            vmem_we    = 1'b1;
                            vmem_waddr = addr(r_cur);
                        end
                    end
                    llc_pkg::OP_ADVANCE: begin
                        if (live(r_cur)) begin
                            n_cur = r_t1;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            S_WR_B: begin
                case (r_op)
                    llc_pkg::OP_DEL_AFTER: begin
                        lmem_we    = 1'b1;
                        lmem_waddr = addr(r_t1);
                        lmem_wdata = r_free;
                        n_free     = r_t1;
                    end
                    llc_pkg::OP_INS_AFTER: begin
                        lmem_we    = 1'b1;
                        lmem_waddr = addr(r_cur);
                        lmem_wdata = r_node;
                    end
                    default: begin
                    end
                endcase
                n_state = S_DONE;
            end

            // hold until the output register is free
            S_DONE: begin
                if (!r_oval || o_rsp.ready) begin
                    n_oval  = 1'b1;
                    n_o_rd  = r_rd;
                    n_o_st  = r_status;
                    n_o_act = live(r_cur);
                    n_o_emp = !live(r_head);
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= NIL;
            r_cur   <= NIL;
            r_free  <= NIL;
            r_nu    <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_cur   <= n_cur;
            r_free  <= n_free;
            r_nu    <= n_nu;
            r_oval  <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_val    <= n_val;
        r_t1     <= n_t1;
        r_node   <= n_node;
        r_rd     <= n_rd;
        r_status <= n_status;
        r_o_rd   <= n_o_rd;
        r_o_st   <= n_o_st;
        r_o_act  <= n_o_act;
        r_o_emp  <= n_o_emp;
    end

    assign i_cmd.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_oval;
    assign o_rsp.read_value = r_o_rd;
    assign o_rsp.status     = r_o_st;
    assign o_rsp.is_active  = r_o_act;
    assign o_rsp.is_empty   = r_o_emp;

endmodule
`default_nettype wire

/* hw/rtl/llc_checker.sv */
// Port-level assertions for the linked-list cursor engine, bound to the top level.
`default_nettype none
module llc_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_in_valid,
    input wire                              i_in_ready,
    input wire                              i_out_valid,
    input wire                              i_out_ready,
    input wire signed [llc_pkg::VAL_W-1:0]  i_read_value,
    input wire [llc_pkg::ST_W-1:0]          i_status,
    input wire                              i_is_active,
    input wire                              i_is_empty
);

    // hold a stalled response
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("response dropped while stalled");

    // one command in flight: no accept on the cycle after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command accepted while another is in flight");

    // any response with an error status, such as a failed read, returns zero
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != llc_pkg::ST_OK) |-> i_read_value == '0)
        else $error("nonzero read value with error status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == llc_pkg::ST_OK) || (i_status == llc_pkg::ST_NO_NODE)
                        || (i_status == llc_pkg::ST_FULL))
        else $error("undefined status code");

    // the cursor is never active on an empty list
    a_cursor_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_is_empty |-> !i_is_active)
        else $error("cursor active on empty list");

endmodule

bind linked_list_cursor_engine llc_checker u_llc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_cmd.valid),
    .i_in_ready   (i_cmd.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_read_value (o_rsp.read_value),
    .i_status     (o_rsp.status),
    .i_is_active  (o_rsp.is_active),
    .i_is_empty   (o_rsp.is_empty)
);
`default_nettype wire

/* tb/linked_list_cursor_engine_tb.sv */
// Self-checking testbench for the linked-list cursor engine: shadow list model plus random traffic.
`timescale 1ns / 1ps
module linked_list_cursor_engine_tb;
    import llc_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int RESET_CYCLES = 10;
    localparam int NODES       = NODE_COUNT_DEF;
    localparam int RANDOM_CMDS = 1000;
    localparam int IDLE_PCT    = 38;
    // No idling on either side while the count of commands sent lies between these bounds.
    localparam int QUIET_FROM  = 300;
    localparam int QUIET_TO    = 550;
    // Long receiver hold-off that backs the command side up.
    localparam int PRESSURE_AT = 700;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;
    // Op codes past the last defined command: the block must treat them as no-ops.
    localparam t_op OP_SPARE_FIRST = OP_ADVANCE + 4'd1;
    localparam t_op OP_SPARE_LAST  = '1;

    typedef logic [8:0] idx_t;
    localparam idx_t NIL = idx_t'(NODES);

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        t_status                 status;
        logic                    is_active;
        logic                    is_empty;
    } rsp_t;

    // Shadow copy of the node pool; predicts one response per accepted command.
    class list_shadow;
        logic signed [VAL_W-1:0] node_val [NODES];
        idx_t                    node_next [NODES];
        idx_t                    head_ptr;
        idx_t                    cursor_ptr;
        idx_t                    free_ptr;
        idx_t                    fresh_count;
        rsp_t                    pending [$];
        int unsigned             errors;

        function new();
            empty_list();
            errors = 0;
        endfunction

        // Drop every node at once; node storage keeps stale contents.
        function void empty_list();
            head_ptr    = NIL;
            cursor_ptr  = NIL;
            free_ptr    = NIL;
            fresh_count = '0;
        endfunction

        // Take a node off the free chain first, else the next never-used one.
        function idx_t take_node();
            idx_t n;
            if (free_ptr != NIL) begin
                n = free_ptr;
                free_ptr = node_next[n];
                return n;
            end
            if (fresh_count < NIL) begin
                n = fresh_count;
                fresh_count++;
                return n;
            end
            return NIL;
        endfunction

        function void give_node(idx_t idx);
            node_next[idx] = free_ptr;
            free_ptr = idx;
        endfunction

        function void note_command(t_op op, logic signed [VAL_W-1:0] val);
            rsp_t r;
            idx_t n;
            idx_t victim;
            r = '0;
            r.status = ST_OK;
            case (op)
                OP_CLEAR: empty_list();
                OP_INS_HEAD: begin
                    n = take_node();
                    if (n == NIL) begin
                        r.status = ST_FULL;
                    end else begin
                        node_val[n]  = val;
                        node_next[n] = head_ptr;
                        head_ptr     = n;
                    end
                end
                OP_CUR_TO_HEAD: cursor_ptr = head_ptr;
                OP_READ_HEAD: begin
                    if (head_ptr != NIL) r.read_value = node_val[head_ptr];
                    else r.status = ST_NO_NODE;
                end
                OP_DEL_HEAD: begin
                    // The cursor falls off with the head, even on an empty list.
                    if (cursor_ptr == head_ptr) cursor_ptr = NIL;
                    if (head_ptr != NIL) begin
                        victim   = head_ptr;
                        head_ptr = node_next[victim];
                        give_node(victim);
                    end
                end
                OP_DEL_AFTER: begin
                    if (cursor_ptr != NIL) begin
                        victim = node_next[cursor_ptr];
                        if (victim != NIL) begin
                            node_next[cursor_ptr] = node_next[victim];
                            give_node(victim);
                        end
                    end
                end
                OP_INS_AFTER: begin
                    // Inactive cursor: nothing happens, not even a full-pool status.
                    if (cursor_ptr != NIL) begin
                        n = take_node();
                        if (n == NIL) begin
                            r.status = ST_FULL;
                        end else begin
                            node_val[n]           = val;
                            node_next[n]          = node_next[cursor_ptr];
                            node_next[cursor_ptr] = n;
                        end
                    end
                end
                OP_READ_CUR: begin
                    if (cursor_ptr != NIL) r.read_value = node_val[cursor_ptr];
                    else r.status = ST_NO_NODE;
                end
                OP_WRITE_CUR: if (cursor_ptr != NIL) node_val[cursor_ptr] = val;
                OP_ADVANCE:   if (cursor_ptr != NIL) cursor_ptr = node_next[cursor_ptr];
                default: ;
            endcase
            r.is_active = (cursor_ptr != NIL);
            r.is_empty  = (head_ptr == NIL);
            pending.push_back(r);
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (pending.size() == 0) begin
                $error("response transaction with no command outstanding");
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.read_value !== want.read_value) begin
                $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.is_active !== want.is_active) begin
                $error("is_active: expected %0b, got %0b", want.is_active, got.is_active);
                errors++;
            end
            if (got.is_empty !== want.is_empty) begin
                $error("is_empty: expected %0b, got %0b", want.is_empty, got.is_empty);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    llc_cmd_if cmd_ch ();
    llc_rsp_if rsp_ch ();

    list_shadow sb = new();

    int unsigned cmds_sent = 0;
    int unsigned hold_left = 0;
    bit          pressure_done = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    linked_list_cursor_engine u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    // Both sides run flat out through the middle of the run.
    function automatic bit no_idle_window();
        return cmds_sent >= QUIET_FROM && cmds_sent < QUIET_TO;
    endfunction

    // Favor the edges of the value range; otherwise any 32-bit pattern.
    function automatic logic signed [VAL_W-1:0] rand_value();
        case ($urandom_range(9))
            0: return {1'b0, {(VAL_W-1){1'b1}}};
            1: return {1'b1, {(VAL_W-1){1'b0}}};
            2: return '0;
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    // General command mix, weighted so the list tends to grow.
    function automatic t_op pick_op();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 3)  return OP_CLEAR;
        if (r < 25) return OP_INS_HEAD;
        if (r < 33) return OP_CUR_TO_HEAD;
        if (r < 40) return OP_READ_HEAD;
        if (r < 50) return OP_DEL_HEAD;
        if (r < 58) return OP_DEL_AFTER;
        if (r < 72) return OP_INS_AFTER;
        if (r < 80) return OP_READ_CUR;
        if (r < 87) return OP_WRITE_CUR;
        if (r < 97) return OP_ADVANCE;
        return t_op'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
    endfunction

    // Cursor-centric mix used while walking the list.
    function automatic t_op pick_cursor_op();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 35) return OP_ADVANCE;
        if (r < 55) return OP_READ_CUR;
        if (r < 70) return OP_WRITE_CUR;
        if (r < 85) return OP_INS_AFTER;
        return OP_DEL_AFTER;
    endfunction

    // Offer one command transaction, optionally after a random gap; hold valid
    // high on return so back-to-back commands can follow without a gap.
    task automatic send_cmd(input t_op op, input logic signed [VAL_W-1:0] val);
        if (!no_idle_window()) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                cmd_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.op    <= op;
        cmd_ch.value <= val;
        do @(posedge i_clk); while (!cmd_ch.ready);
        cmds_sent++;
    endtask

    // Observe both channels on the clock edge; values seen here are the ones
    // the block saw, since every driver updates with nonblocking assignments.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cmd_ch.valid && cmd_ch.ready)
                sb.note_command(cmd_ch.op, cmd_ch.value);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_response('{rsp_ch.read_value, rsp_ch.status,
                                    rsp_ch.is_active, rsp_ch.is_empty});
        end
    end

    // Response sink: random stalls, a quiet stretch, and one long hold-off
    // that fills the output register and stalls the command side.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!pressure_done && cmds_sent >= PRESSURE_AT) begin
                pressure_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else if (no_idle_window()) begin
                rsp_ch.ready <= 1'b1;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int unsigned directed_end;
        int unsigned span;
        bit          pool_filled;
        pool_filled  = 1'b0;
        i_rst_n      = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.op    = OP_CLEAR;
        cmd_ch.value = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed first: read, delete, insert-after, write and advance on empty list, no cursor.
        send_cmd(OP_READ_HEAD, '0);
        send_cmd(OP_READ_CUR, '0);
        send_cmd(OP_DEL_HEAD, '0);
        send_cmd(OP_DEL_AFTER, '0);
        send_cmd(OP_INS_AFTER, 32'sd7);
        send_cmd(OP_WRITE_CUR, 32'sd9);
        send_cmd(OP_ADVANCE, '0);
        // Build four nodes holding the value extremes.
        send_cmd(OP_INS_HEAD, {1'b0, {(VAL_W-1){1'b1}}});
        send_cmd(OP_INS_HEAD, {1'b1, {(VAL_W-1){1'b0}}});
        send_cmd(OP_INS_HEAD, '0);
        send_cmd(OP_INS_HEAD, '1);
        send_cmd(OP_CUR_TO_HEAD, '0);
        send_cmd(OP_READ_CUR, '0);
        send_cmd(OP_INS_AFTER, 32'sd1);
        send_cmd(OP_DEL_AFTER, '0);
        send_cmd(OP_WRITE_CUR, 32'h5A5A_5A5A);
        send_cmd(OP_READ_HEAD, '0);
        // Walk to the tail, try delete-after there, then step off the end.
        repeat (3) send_cmd(OP_ADVANCE, '0);
        send_cmd(OP_DEL_AFTER, '0);
        send_cmd(OP_ADVANCE, '0);
        // Delete the head with the cursor on it: the cursor must drop.
        send_cmd(OP_CUR_TO_HEAD, '0);
        send_cmd(OP_DEL_HEAD, '0);
        send_cmd(OP_SPARE_FIRST, '1);
        send_cmd(OP_SPARE_LAST, '1);
        send_cmd(OP_CLEAR, '0);
        directed_end = cmds_sent;

        // Random episodes until the command budget is spent.
        while (cmds_sent - directed_end < RANDOM_CMDS) begin
            if (!pool_filled && cmds_sent - directed_end >= 350) begin
                // Fill the pool past its limit, free a few nodes from both
                // ends of the cursor, then refill through the free chain.
                pool_filled = 1'b1;
                send_cmd(OP_CLEAR, rand_value());
                send_cmd(OP_INS_HEAD, rand_value());
                send_cmd(OP_CUR_TO_HEAD, rand_value());
                repeat (NODES + 4)
                    send_cmd($urandom_range(1) ? OP_INS_HEAD : OP_INS_AFTER, rand_value());
                repeat (3) send_cmd(OP_DEL_HEAD, rand_value());
                send_cmd(OP_CUR_TO_HEAD, rand_value());
                repeat (3) send_cmd(OP_DEL_AFTER, rand_value());
                repeat (8)
                    send_cmd($urandom_range(1) ? OP_INS_HEAD : OP_INS_AFTER, rand_value());
            end else begin
                case ($urandom_range(2))
                    0: begin
                        span = $urandom_range(8, 1);
                        repeat (span) send_cmd(OP_INS_HEAD, rand_value());
                    end
                    1: begin
                        span = $urandom_range(15, 3);
                        send_cmd(OP_CUR_TO_HEAD, rand_value());
                        repeat (span) send_cmd(pick_cursor_op(), rand_value());
                    end
                    default: begin
                        span = $urandom_range(20, 5);
                        repeat (span) send_cmd(pick_op(), rand_value());
                    end
                endcase
            end
        end
        cmd_ch.valid <= 1'b0;

        // Drain outstanding responses, then watch for strays.
        do @(posedge i_clk); while (sb.pending.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
